// ===== rtl/ipv4_header_receive_filter_macros.svh =====
// Assertion macros used by the IPv4 header receive filter checker.
`ifndef IPV4_HEADER_RECEIVE_FILTER_MACROS_SVH
`define IPV4_HEADER_RECEIVE_FILTER_MACROS_SVH

// Concurrent assertion sampled on clk, disabled while rst_n is low.
`define IPV4RF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion sampled on clk, also checked during reset.
`define IPV4RF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/ipv4rf_pkg.sv =====
// Types, constants and helper functions for the IPv4 header receive filter.
package ipv4rf_pkg;

  localparam int unsigned IDX_W = 4;

  localparam logic [IDX_W-1:0] HEADER_WORDS  = 4'd10;
  localparam logic [IDX_W-1:0] WORD_LENGTH   = 4'd1;
  localparam logic [IDX_W-1:0] WORD_FLAGS    = 4'd3;
  localparam logic [IDX_W-1:0] WORD_PROTOCOL = 4'd4;
  localparam logic [IDX_W-1:0] WORD_SRC_HI   = 4'd6;
  localparam logic [IDX_W-1:0] WORD_SRC_LO   = 4'd7;
  localparam logic [IDX_W-1:0] WORD_DST_HI   = 4'd8;
  localparam logic [IDX_W-1:0] WORD_LAST     = 4'd9;

  localparam int unsigned MF_BIT = 13;

  localparam logic [15:0] SUM_INIT  = 16'hFFFF;
  localparam logic [31:0] BROADCAST = 32'hFFFF_FFFF;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  typedef enum logic [1:0] {
    VERDICT_ACCEPT     = 2'd0,
    VERDICT_BAD_CSUM   = 2'd1,
    VERDICT_WRONG_DEST = 2'd2,
    VERDICT_FRAGMENT   = 2'd3
  } verdict_t;

  typedef enum logic [1:0] {
    CLASS_ICMP  = 2'd0,
    CLASS_UDP   = 2'd1,
    CLASS_TCP   = 2'd2,
    CLASS_OTHER = 2'd3
  } proto_class_t;

  typedef struct packed {
    logic [15:0] sum;
    logic        more_frags;
    logic [7:0]  protocol;
    logic [31:0] dest;
    logic [31:0] own_address;
  } hdr_status_t;

  typedef struct packed {
    verdict_t     verdict;
    proto_class_t proto_class;
  } hdr_result_t;

  function automatic logic [15:0] fold_add(input logic [15:0] acc, input logic [15:0] w);
    logic [16:0] s;
    s = {1'b0, acc} + {1'b0, w};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

// ===== rtl/ipv4rf_verdict.sv =====
// Priority checks and protocol classification for a completed IPv4 header.
module ipv4rf_verdict (
  input  ipv4rf_pkg::hdr_status_t status,
  output ipv4rf_pkg::hdr_result_t result
);

  logic csum_bad;
  logic dest_bad;

  assign csum_bad = (status.sum != ipv4rf_pkg::SUM_INIT);
  assign dest_bad = (status.own_address != 32'd0) &&
                    (status.dest != ipv4rf_pkg::BROADCAST) &&
                    (status.dest != status.own_address);

  always_comb begin
    priority if (csum_bad) begin
      result.verdict = ipv4rf_pkg::VERDICT_BAD_CSUM;
    end else if (dest_bad) begin
      result.verdict = ipv4rf_pkg::VERDICT_WRONG_DEST;
    end else if (status.more_frags) begin
      result.verdict = ipv4rf_pkg::VERDICT_FRAGMENT;
    end else begin
      result.verdict = ipv4rf_pkg::VERDICT_ACCEPT;
    end
    unique case (status.protocol)
      ipv4rf_pkg::PROTO_ICMP: result.proto_class = ipv4rf_pkg::CLASS_ICMP;
      ipv4rf_pkg::PROTO_UDP:  result.proto_class = ipv4rf_pkg::CLASS_UDP;
      ipv4rf_pkg::PROTO_TCP:  result.proto_class = ipv4rf_pkg::CLASS_TCP;
      default:                result.proto_class = ipv4rf_pkg::CLASS_OTHER;
    endcase
  end

endmodule

// ===== rtl/ipv4_header_receive_filter.sv =====
// A header word is registered on accept; the tenth word's result is then registered.
// Throughput: one header word per cycle unless stalled; one input stage feeds the result register.
// The input stage stalls only when a result is due while the result register is still held.
// Reset (rst_n low, synchronous): clears word count, sum to 0xFFFF, own address and all valids.
// Held header fields are not reset; they are always captured before a result uses them.
module ipv4_header_receive_filter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,   // own_address
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,      // [15:0] header_word
  input  logic        in_tuser,      // [0] start_of_header
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata      // [1:0] verdict, [3:2] protocol_class,
                                     // [35:4] source_address, [51:36] total_length, [55:52] zero
);

  logic [31:0] own_address_r;

  logic        stg_valid_r;
  logic [15:0] stg_word_r;
  logic        stg_start_r;

  logic [ipv4rf_pkg::IDX_W-1:0] word_index_r;
  logic [ipv4rf_pkg::IDX_W-1:0] word_index_nxt;
  logic [15:0]                  sum_r;
  logic [15:0]                  sum_nxt;
  logic [15:0]                  length_r;
  logic                         mf_r;
  logic [7:0]                   protocol_r;
  logic [31:0]                  source_r;
  logic [15:0]                  dest_hi_r;

  logic                         out_valid_r;
  logic [55:0]                  out_data_r;

  logic [ipv4rf_pkg::IDX_W-1:0] eff_idx;
  logic [15:0]                  sum_base;
  logic                         active;
  logic                         produces;
  logic                         out_free;
  logic                         stg_go;

  ipv4rf_pkg::hdr_status_t status;
  ipv4rf_pkg::hdr_result_t result;

  assign eff_idx  = stg_start_r ? '0 : word_index_r;
  assign sum_base = stg_start_r ? ipv4rf_pkg::SUM_INIT : sum_r;
  assign active   = (eff_idx < ipv4rf_pkg::HEADER_WORDS);
  assign produces = active && (eff_idx == ipv4rf_pkg::WORD_LAST);
  assign out_free = !out_valid_r || out_tready;
  assign stg_go   = stg_valid_r && (!produces || out_free);

  assign in_tready = !stg_valid_r || stg_go;

  assign sum_nxt        = ipv4rf_pkg::fold_add(sum_base, stg_word_r);
  assign word_index_nxt = eff_idx + 4'd1;

  assign status.sum         = sum_nxt;
  assign status.more_frags  = mf_r;
  assign status.protocol    = protocol_r;
  assign status.dest        = {dest_hi_r, stg_word_r};
  assign status.own_address = own_address_r;

  ipv4rf_verdict u_verdict (
    .status (status),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_address_r <= 32'd0;
    end else if (cfg_wr_en) begin
      own_address_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_tready) begin
      stg_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      stg_word_r  <= in_tdata;
      stg_start_r <= in_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_index_r <= '0;
      sum_r        <= ipv4rf_pkg::SUM_INIT;
    end else if (stg_go && active) begin
      word_index_r <= word_index_nxt;
      sum_r        <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_go && active) begin
      unique case (eff_idx)
        ipv4rf_pkg::WORD_LENGTH:   length_r   <= stg_word_r;
        ipv4rf_pkg::WORD_FLAGS:    mf_r       <= stg_word_r[ipv4rf_pkg::MF_BIT];
        ipv4rf_pkg::WORD_PROTOCOL: protocol_r <= stg_word_r[7:0];
        ipv4rf_pkg::WORD_SRC_HI:   source_r[31:16] <= stg_word_r;
        ipv4rf_pkg::WORD_SRC_LO:   source_r[15:0]  <= stg_word_r;
        ipv4rf_pkg::WORD_DST_HI:   dest_hi_r  <= stg_word_r;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stg_go && produces) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_go && produces) begin
      out_data_r <= {4'd0, length_r, source_r, result.proto_class, result.verdict};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== rtl/ipv4rf_checker.sv =====
// Port-level assertion checker for the IPv4 header receive filter, with its bind.
`include "ipv4_header_receive_filter_macros.svh"

module ipv4rf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata
);

  `IPV4RF_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result changed while stalled")
  `IPV4RF_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_tvalid, "result valid after reset")
  `IPV4RF_ASSERT(a_stall_source, !in_tready |-> out_tvalid && !out_tready, "input stalled without downstream backpressure")
  `IPV4RF_ASSERT(a_pad_zero, out_tvalid |-> out_tdata[55:52] == 4'd0, "result padding not zero")

endmodule

bind ipv4_header_receive_filter ipv4rf_checker u_ipv4rf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
